>>> design/swa_pkg.sv
package swa_pkg;

  // Sizing
  localparam int MAX_PACKETS = 4096;
  localparam int MAX_WINDOW  = 32;
  localparam int ADDR_W      = $clog2(MAX_PACKETS);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int WIN_W       = 6;
  localparam int TMO_W       = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // Ack map entries hold the epoch of the transfer that acked them.
  localparam int EPOCH_W = 8;
  typedef logic [EPOCH_W-1:0] epoch_t;
  localparam epoch_t EPOCH_NONE  = '0;
  localparam epoch_t EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t EPOCH_LAST  = '1;

  // Reset values of the config registers
  localparam logic [WIN_W-1:0] WINDOW_RST  = WIN_W'(5);
  localparam logic [CNT_W-1:0] COUNT_RST   = CNT_W'(1);
  localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(3);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW  = 2'd0,
    CFG_COUNT   = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_e;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [WIN_W-1:0] win;
    logic [CNT_W-1:0] cnt;
    logic [TMO_W-1:0] tmo;
  } cfg_t;

  // Ack map access
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    epoch_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // One result word
  typedef struct packed {
    logic              send_valid;
    logic [ADDR_W-1:0] send_seq;
    logic              is_resend;
    logic [CNT_W-1:0]  window_base;
    logic              all_acked;
    logic              bad_ack;
    logic              last;
  } result_t;

endpackage

>>> design/sliding_window_arq_sender.sv
// Sender side of a selective-repeat sliding-window ARQ. An item is taken
// when start_i is high and busy_o is low: action 0 starts a transfer, 1
// records the ack for ack_seq_i, 2 is one timer tick, 3 does nothing. Each
// item yields one or more result words on the cycles after it is taken,
// each shown for exactly one cycle with result_valid_o high and back to
// back, the final one with last_o high. Result words cannot be stalled: the
// receiver must take every word in the cycle it is shown. A tick, a bad or
// idle ack and a no-op give one word. A start gives one word per packet
// sent (up to the window), or one if it sends none. An ack while a transfer
// runs first checks the base entry and gives one word if the base stays;
// if it moves, the map entries it passes are walked, then one word per new
// send, or one if there is none. The ack map lives in a single 4096-entry
// memory tagged with a transfer epoch, so a start needs no clearing; after
// reset and on every 255th start a clearing pass writes the memory, one
// entry a cycle, with busy_o high. Config writes are taken any cycle but
// must only happen between items.
module sliding_window_arq_sender (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command side
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      action_i,
  input  logic [swa_pkg::ADDR_W-1:0]      ack_seq_i,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [swa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [swa_pkg::CFG_W-1:0]       cfg_wdata_i,
  // result words
  output logic                            result_valid_o,
  output logic                            send_valid_o,
  output logic [swa_pkg::ADDR_W-1:0]      send_seq_o,
  output logic                            is_resend_o,
  output logic [swa_pkg::CNT_W-1:0]       window_base_o,
  output logic                            all_acked_o,
  output logic                            bad_ack_o,
  output logic                            last_o
);
  import swa_pkg::*;

  // config registers, raw as written
  logic [WIN_W-1:0] win_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TMO_W-1:0] tmo_q;
  cfg_t             cfg;

  mem_req_t         mem_req;
  epoch_t           mem_rd_data;
  logic             res_valid;
  result_t          res;
  logic             res_valid_q;
  result_t          res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_RST;
      cnt_q <= COUNT_RST;
      tmo_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW:  win_q <= cfg_wdata_i[WIN_W-1:0];
        CFG_COUNT:   cnt_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_TIMEOUT: tmo_q <= cfg_wdata_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp: window 0 acts as 1, oversize window and count saturate
  always_comb begin
    if (win_q == '0) begin
      cfg.win = WIN_W'(1);
    end else if (int'(win_q) > MAX_WINDOW) begin
      cfg.win = WIN_W'(MAX_WINDOW);
    end else begin
      cfg.win = win_q;
    end
    cfg.cnt = (int'(cnt_q) > MAX_PACKETS) ? CNT_W'(MAX_PACKETS) : cnt_q;
    cfg.tmo = tmo_q;
  end

  swa_ack_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

  swa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .action_i    (action_e'(action_i)),
    .ack_seq_i   (ack_seq_i),
    .cfg_i       (cfg),
    .mem_o       (mem_req),
    .rd_data_i   (mem_rd_data),
    .busy_o      (busy_o),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register: one word per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign result_valid_o = res_valid_q;
  assign send_valid_o   = res_q.send_valid;
  assign send_seq_o     = res_q.send_seq;
  assign is_resend_o    = res_q.is_resend;
  assign window_base_o  = res_q.window_base;
  assign all_acked_o    = res_q.all_acked;
  assign bad_ack_o      = res_q.bad_ack;
  assign last_o         = res_q.last;

`ifndef NO_ASSERTIONS
  // words of one item come back to back
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("result burst broken before last word");

  // a timeout resend is always a single-word result
  a_resend_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && send_valid_o && is_resend_o |-> last_o)
    else $error("resend word not marked last");

  // a finished transfer never requests a send
  a_done_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && all_acked_o |-> !send_valid_o)
    else $error("send requested after transfer complete");

  // new sends never fall below the window base
  a_send_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && send_valid_o && !is_resend_o |->
      {1'b0, send_seq_o} >= window_base_o)
    else $error("new send below window base");
`endif

endmodule

>>> design/swa_ack_mem.sv
module swa_ack_mem (
  input  logic              clk_i,
  input  swa_pkg::mem_req_t req_i,
  output swa_pkg::epoch_t   rd_data_o
);
  import swa_pkg::*;

  epoch_t mem_q [MAX_PACKETS];
  epoch_t rd_data_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_data_q <= mem_q[req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/swa_ctrl.sv
module swa_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  swa_pkg::action_e            action_i,
  input  logic [swa_pkg::ADDR_W-1:0]  ack_seq_i,
  input  swa_pkg::cfg_t               cfg_i,
  output swa_pkg::mem_req_t           mem_o,
  input  swa_pkg::epoch_t             rd_data_i,
  output logic                        busy_o,
  output logic                        res_valid_o,
  output swa_pkg::result_t            res_o
);
  import swa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHK   = 4'b0010,
    ST_SEND  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  base_q, base_d;
  logic [CNT_W-1:0]  next_q, next_d;
  logic [TMO_W-1:0]  timer_q, timer_d;
  logic              running_q, running_d;
  epoch_t            epoch_q, epoch_d;
  logic              fwd_q, fwd_d;
  logic              adv_q, adv_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  logic [CNT_W-1:0]  base_inc;
  logic [CNT_W-1:0]  next_inc;
  logic [TMO_W-1:0]  timer_inc;
  logic              base_open;
  logic              room_now;
  logic              room_after;
  logic              entry_acked;

  assign base_inc    = base_q + CNT_W'(1);
  assign next_inc    = next_q + CNT_W'(1);
  assign timer_inc   = (&timer_q) ? timer_q : timer_q + TMO_W'(1);
  assign base_open   = base_q < cfg_i.cnt;
  assign room_now    = (next_q < cfg_i.cnt) &&
                       ((next_q - base_q) < CNT_W'(cfg_i.win));
  assign room_after  = (next_inc < cfg_i.cnt) &&
                       ((next_inc - base_q) < CNT_W'(cfg_i.win));
  // first check forwards the ack written in the accept cycle
  assign entry_acked = (rd_data_i == epoch_q) || fwd_q;

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    next_d    = next_q;
    timer_d   = timer_q;
    running_d = running_q;
    epoch_d   = epoch_q;
    fwd_d     = fwd_q;
    adv_d     = adv_q;
    pend_d    = pend_q;
    clr_cnt_d = clr_cnt_q;

    mem_o.we    = 1'b0;
    mem_o.waddr = ack_seq_i;
    mem_o.wdata = epoch_q;
    mem_o.raddr = base_q[ADDR_W-1:0];

    res_valid_o       = 1'b0;
    res_o.send_valid  = 1'b0;
    res_o.send_seq    = '0;
    res_o.is_resend   = 1'b0;
    res_o.window_base = base_q;
    res_o.all_acked   = !base_open;
    res_o.bad_ack     = 1'b0;
    res_o.last        = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (action_i)
            ACT_START: begin
              base_d    = '0;
              next_d    = '0;
              timer_d   = '0;
              running_d = (cfg_i.cnt != '0);
              if (epoch_q == EPOCH_LAST) begin
                pend_d    = 1'b1;
                clr_cnt_d = '0;
                state_d   = ST_CLEAR;
              end else begin
                epoch_d = epoch_q + EPOCH_FIRST;
                state_d = ST_SEND;
              end
            end
            ACT_ACK: begin
              if ({1'b0, ack_seq_i} >= cfg_i.cnt) begin
                res_valid_o   = 1'b1;
                res_o.bad_ack = 1'b1;
              end else begin
                mem_o.we = 1'b1;
                if (running_q && base_open) begin
                  fwd_d   = ({1'b0, ack_seq_i} == base_q);
                  adv_d   = 1'b0;
                  state_d = ST_CHK;
                end else begin
                  res_valid_o = 1'b1;
                end
              end
            end
            ACT_TICK: begin
              res_valid_o = 1'b1;
              if (running_q && base_open) begin
                if (timer_inc >= cfg_i.tmo) begin
                  timer_d          = '0;
                  res_o.send_valid = 1'b1;
                  res_o.send_seq   = base_q[ADDR_W-1:0];
                  res_o.is_resend  = 1'b1;
                end else begin
                  timer_d = timer_inc;
                end
              end
            end
            ACT_NOP: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end

      // walk the map one entry per cycle; next read is prefetched
      ST_CHK: begin
        mem_o.raddr = base_inc[ADDR_W-1:0];
        fwd_d       = 1'b0;
        if (entry_acked && base_open) begin
          base_d = base_inc;
          adv_d  = 1'b1;
        end else if (!adv_q) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          if (next_q < base_q) begin
            next_d = base_q;
          end
          timer_d = '0;
          if (!base_open) begin
            running_d = 1'b0;
          end
          state_d = ST_SEND;
        end
      end

      ST_SEND: begin
        res_valid_o = 1'b1;
        if (room_now) begin
          res_o.send_valid = 1'b1;
          res_o.send_seq   = next_q[ADDR_W-1:0];
          res_o.last       = !room_after;
          next_d           = next_inc;
          if (!room_after) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_CLEAR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clr_cnt_q;
        mem_o.wdata = EPOCH_NONE;
        clr_cnt_d   = clr_cnt_q + ADDR_W'(1);
        if (&clr_cnt_q) begin
          epoch_d = EPOCH_FIRST;
          pend_d  = 1'b0;
          state_d = pend_q ? ST_SEND : ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      base_q    <= '0;
      next_q    <= '0;
      timer_q   <= '0;
      running_q <= 1'b0;
      epoch_q   <= EPOCH_FIRST;
      fwd_q     <= 1'b0;
      adv_q     <= 1'b0;
      pend_q    <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      next_q    <= next_d;
      timer_q   <= timer_d;
      running_q <= running_d;
      epoch_q   <= epoch_d;
      fwd_q     <= fwd_d;
      adv_q     <= adv_d;
      pend_q    <= pend_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
